/* rtl/plac_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plac_pkg: Phong light accumulator package
// Shared widths, register indexes, reset values and fixed-point helpers.
// ----------------------------------------------------------------------------
package plac_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_AMBIENT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUADRATIC = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONSTANT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT  = 3'd4;

	localparam int AMB_W  = 13;
	localparam int ATC_W  = 16;
	localparam int EXP_W  = 8;
	localparam int REFL_W = 13;
	localparam int OUT_W  = 16;

	localparam logic [AMB_W-1:0] AMBIENT_RST   = 13'd410;
	localparam logic [ATC_W-1:0] QUADRATIC_RST = 16'd131;
	localparam logic [ATC_W-1:0] LINEAR_RST    = 16'd1311;
	localparam logic [ATC_W-1:0] CONSTANT_RST  = 16'd13107;
	localparam logic [EXP_W-1:0] EXPONENT_RST  = 8'd100;

	localparam int SUM_W = 20;
	localparam int ADD_W = 40;
	localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;
	localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

	localparam int D2_W = 40;
	localparam logic [D2_W-1:0] DIST2_MAX = 40'hFF_FFFF_FFFF;

	localparam int UNIT_W = 16;
	localparam int UQ_W   = 15;
	localparam logic [UQ_W-1:0] UNIT_ONE = 15'd16384;
	localparam logic [REFL_W-1:0] REFL_ONE = 13'd4096;

	localparam int MUL_W   = 33;
	localparam int PROD_W  = 66;
	localparam int ACC_W   = 36;
	localparam int DEN_W   = 58;
	localparam int ATT_W   = 17;
	localparam int T_W     = 28;
	localparam int R_W     = 18;
	localparam int NL_W    = 18;
	localparam int R2_W    = 37;
	localparam int SQ_W    = 56;
	localparam int ROOT_W  = 28;
	localparam int DIST8_W = 20;
	localparam int DVN_W   = 49;
	localparam int DVQ_W   = 16;
	localparam int DVS_W   = DEN_W + DVQ_W - 1;
	localparam int DVC_W   = 5;

	localparam logic [DVN_W-1:0] ATT_NUM = 49'h1_0000_0000_0000;
	localparam logic [DEN_W-1:0] ATT_LIM = 58'h1_0000_0000;
	localparam logic [ATT_W-1:0] ATT_ONE = 17'h10000;

	function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] s, logic [ADD_W-1:0] a);
		logic [ADD_W:0] t;
		t = (ADD_W+1)'(s) + (ADD_W+1)'(a);
		return (t > (ADD_W+1)'(SUM_MAX)) ? SUM_MAX : t[SUM_W-1:0];
	endfunction

	// divide by 2^14, rounding toward zero
	function automatic logic signed [ACC_W-1:0] tdiv14(logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] b;
		b = x[ACC_W-1] ? (x + ACC_W'(16383)) : x;
		return b >>> 14;
	endfunction

endpackage
`default_nettype wire

/* rtl/phong_light_accumulator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phong_light_accumulator_core: per-light Phong shading accumulator
// Ambient load, diffuse with constant/linear/quadratic attenuation and specular power per
// light, summed in 20-bit saturating RGB accumulators, emitted as Q4.12.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_ready  | hit_point .. last_light (one light a beat)
//  out      | out_valid/ out_ready | color_red, color_green, color_blue
//  cfg      | cfg_write            | cfg_index, cfg_data
//
//  An unlit beat skips the arithmetic units; first_light adds the ambient load. A lit
//  beat's length is set by the 16-step divider (up to seven divides), the 28-step
//  root unit (two roots) and the multiply-register loop of the power.
//  in_ready is high only in idle. One result waits in the output register while
//  the next beat is taken; an emit stalls only if that register is still full.
//  Reset clears the sums and loads register defaults.
// ----------------------------------------------------------------------------
module phong_light_accumulator_core #(
	parameter int COMPONENT_WIDTH = plac_pkg::COMPONENT_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [3*COMPONENT_WIDTH-1:0]          hit_point,
	input  wire logic [3*COMPONENT_WIDTH-1:0]          surface_normal,
	input  wire logic [3*COMPONENT_WIDTH-1:0]          view_dir,
	input  wire logic [3*COMPONENT_WIDTH-1:0]          object_color,
	input  wire logic [plac_pkg::REFL_W-1:0]           reflectivity,
	input  wire logic [3*COMPONENT_WIDTH-1:0]          light_pos,
	input  wire logic                                  in_shadow,
	input  wire logic                                  light_valid,
	input  wire logic                                  first_light,
	input  wire logic                                  last_light,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [plac_pkg::OUT_W-1:0]                 color_red,
	output logic [plac_pkg::OUT_W-1:0]                 color_green,
	output logic [plac_pkg::OUT_W-1:0]                 color_blue,
	input  wire logic                                  cfg_write,
	input  wire logic [plac_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [plac_pkg::CFG_W-1:0]            cfg_data
);

	localparam int CW  = COMPONENT_WIDTH;
	localparam int FW  = 3 * CW;
	localparam int FWK = (FW > 64) ? 64 : FW;
	localparam int DW  = CW + 1;
	localparam int D2A_W = 2 * DW + 2;

	localparam int MUL_W  = plac_pkg::MUL_W;
	localparam int PROD_W = plac_pkg::PROD_W;
	localparam int ACC_W  = plac_pkg::ACC_W;
	localparam int SUM_W  = plac_pkg::SUM_W;
	localparam int ADD_W  = plac_pkg::ADD_W;
	localparam int UNIT_W = plac_pkg::UNIT_W;
	localparam int UQ_W   = plac_pkg::UQ_W;
	localparam int DEN_W  = plac_pkg::DEN_W;
	localparam int DVN_W  = plac_pkg::DVN_W;
	localparam int DVQ_W  = plac_pkg::DVQ_W;
	localparam int DVS_W  = plac_pkg::DVS_W;
	localparam int DVC_W  = plac_pkg::DVC_W;
	localparam int SQ_W   = plac_pkg::SQ_W;
	localparam int ROOT_W = plac_pkg::ROOT_W;
	localparam int R_W    = plac_pkg::R_W;
	localparam int R2_W   = plac_pkg::R2_W;
	localparam int T_W    = plac_pkg::T_W;
	localparam int NL_W   = plac_pkg::NL_W;
	localparam int D2_W   = plac_pkg::D2_W;
	localparam int D2X_W  = (D2A_W > D2_W) ? D2A_W : D2_W;

	typedef enum logic [25:0] {
		S_IDLE = 26'h0000001,
		S_AMB  = 26'h0000002,
		S_CHK  = 26'h0000004,
		S_D2   = 26'h0000008,
		S_SQ1  = 26'h0000010,
		S_DQL  = 26'h0000020,
		S_DQH  = 26'h0000040,
		S_DLN  = 26'h0000080,
		S_ATT  = 26'h0000100,
		S_ATW  = 26'h0000200,
		S_LEN  = 26'h0000400,
		S_LDV  = 26'h0000800,
		S_LWT  = 26'h0001000,
		S_NL   = 26'h0002000,
		S_DF1  = 26'h0004000,
		S_DF2  = 26'h0008000,
		S_DF3  = 26'h0010000,
		S_RN   = 26'h0020000,
		S_RR   = 26'h0040000,
		S_SQ2  = 26'h0080000,
		S_RDV  = 26'h0100000,
		S_RWT  = 26'h0200000,
		S_PV   = 26'h0400000,
		S_POW  = 26'h0800000,
		S_SPC  = 26'h1000000,
		S_EMIT = 26'h2000000
	} state_t;

	state_t state_q;
	logic   ph_q;
	logic [1:0] idx_q;

	// config
	logic [plac_pkg::AMB_W-1:0] ambient_q;
	logic [plac_pkg::ATC_W-1:0] quad_q, lin_q, const_q;
	logic [plac_pkg::EXP_W-1:0] exp_q;

	// latched beat
	logic [FW-1:0] hp_q, nrm_q, vw_q, col_q, lp_q;
	logic [plac_pkg::REFL_W-1:0] refl_q;
	logic shadow_q, lvalid_q, last_q;

	// datapath
	logic [SUM_W-1:0] sum_q [3];
	logic [D2A_W-1:0] d2acc_q;
	logic [D2_W-1:0]  d2_q;
	logic [ROOT_W-1:0] len16_q, rlen_q;
	logic [DEN_W-1:0] den_q;
	logic [plac_pkg::ATT_W-1:0] att_q;
	logic signed [UNIT_W-1:0] l_q [3];
	logic signed [R_W-1:0] r_q [3];
	logic signed [ACC_W-1:0] dacc_q;
	logic signed [NL_W-1:0] nl_q;
	logic [R2_W-1:0] r2acc_q;
	logic [T_W-1:0] t_q;
	logic [UQ_W-1:0] acc_q, p_q;
	logic [plac_pkg::EXP_W-1:0] e_q;
	logic [plac_pkg::OUT_W-1:0] red_q, green_q, blue_q;
	logic out_valid_q;

	// multiplier
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;

	// divider
	logic [DVN_W-1:0] dv_rem_q;
	logic [DVS_W-1:0] dv_dsh_q;
	logic [DVQ_W-1:0] dv_quo_q;
	logic             dv_ovf_q, dv_busy_q;
	logic [DVC_W-1:0] dv_cnt_q;
	logic             dv_go;
	logic [DVN_W-1:0] dv_n;
	logic [DEN_W-1:0] dv_d;
	logic [UQ_W-1:0]  dv_unit;

	// root unit
	logic [SQ_W-1:0] sq_x_q, sq_bit_q;
	logic [SQ_W:0]   sq_r_q;
	logic            sq_busy_q;
	logic [SQ_W:0]   sq_try;

	// component views
	logic [CW-1:0]            colc [3];
	logic signed [DW-1:0]     d_w [3];
	logic signed [UNIT_W-1:0] n_w [3];
	logic signed [UNIT_W-1:0] v_w [3];
	logic [DW-1:0]            dmag;
	logic [R_W-1:0]           rmag;

	logic [D2A_W-1:0] d2_sum;
	logic [D2_W-1:0]  d2_sat;
	logic signed [ACC_W-1:0] dot_sum, dot_t;
	logic [R2_W-1:0] r2_sum;
	logic [plac_pkg::REFL_W-1:0] refl_w;
	logic in_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign color_red   = red_q;
	assign color_green = green_q;
	assign color_blue  = blue_q;

	always_comb begin
		logic signed [MUL_W-1:0] hpt, lpt, nt, vt;
		for (int k = 0; k < 3; k++) begin
			colc[k] = col_q[k*CW +: CW];
			hpt = MUL_W'($signed(hp_q[k*CW +: CW]));
			lpt = MUL_W'($signed(lp_q[k*CW +: CW]));
			nt  = MUL_W'($signed(nrm_q[k*CW +: CW]));
			vt  = MUL_W'($signed(vw_q[k*CW +: CW]));
			d_w[k] = DW'(lpt - hpt);
			n_w[k] = (nt > MUL_W'(16384)) ? UNIT_W'(16384) :
				(nt < -MUL_W'(16384)) ? -UNIT_W'(16384) : UNIT_W'(nt);
			v_w[k] = (vt > MUL_W'(16384)) ? UNIT_W'(16384) :
				(vt < -MUL_W'(16384)) ? -UNIT_W'(16384) : UNIT_W'(vt);
		end
		dmag    = d_w[idx_q][DW-1] ? DW'(-d_w[idx_q]) : DW'(d_w[idx_q]);
		rmag    = r_q[idx_q][R_W-1] ? R_W'(-r_q[idx_q]) : R_W'(r_q[idx_q]);
		d2_sum  = d2acc_q + prod_q[D2A_W-1:0];
		d2_sat  = (D2X_W'(d2_sum) > D2X_W'(plac_pkg::DIST2_MAX)) ? plac_pkg::DIST2_MAX
			: D2_W'(d2_sum);
		dot_sum = dacc_q + ACC_W'(prod_q);
		dot_t   = plac_pkg::tdiv14(dot_sum);
		r2_sum  = r2acc_q + prod_q[R2_W-1:0];
		refl_w  = (refl_q > plac_pkg::REFL_ONE) ? plac_pkg::REFL_ONE : refl_q;
		dv_unit = (dv_ovf_q || dv_quo_q > DVQ_W'(plac_pkg::UNIT_ONE)) ? plac_pkg::UNIT_ONE
			: dv_quo_q[UQ_W-1:0];
		sq_try  = sq_r_q + (SQ_W+1)'(sq_bit_q);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_AMB: begin mul_a = MUL_W'(ambient_q); mul_b = MUL_W'(colc[idx_q]); end
			S_D2:  begin mul_a = MUL_W'(d_w[idx_q]); mul_b = MUL_W'(d_w[idx_q]); end
			S_DQL: begin mul_a = MUL_W'(quad_q); mul_b = MUL_W'(d2_q[31:0]); end
			S_DQH: begin mul_a = MUL_W'(quad_q); mul_b = MUL_W'(d2_q[D2_W-1:32]); end
			S_DLN: begin mul_a = MUL_W'(lin_q); mul_b = MUL_W'(len16_q[ROOT_W-1:8]); end
			S_NL:  begin mul_a = MUL_W'(n_w[idx_q]); mul_b = MUL_W'(l_q[idx_q]); end
			S_DF1: begin mul_a = MUL_W'(nl_q); mul_b = MUL_W'(colc[idx_q]); end
			S_DF2: begin mul_a = MUL_W'(t_q); mul_b = MUL_W'(att_q); end
			S_DF3: begin mul_a = MUL_W'(t_q); mul_b = MUL_W'(plac_pkg::REFL_ONE - refl_w); end
			S_RN:  begin mul_a = MUL_W'(nl_q); mul_b = MUL_W'(n_w[idx_q]); end
			S_RR:  begin mul_a = MUL_W'(r_q[idx_q]); mul_b = MUL_W'(r_q[idx_q]); end
			S_PV:  begin mul_a = MUL_W'(r_q[idx_q]); mul_b = MUL_W'(v_w[idx_q]); end
			S_POW: begin mul_a = MUL_W'(acc_q); mul_b = MUL_W'(p_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		dv_go = 1'b0;
		dv_n  = '0;
		dv_d  = '0;
		unique case (state_q)
			S_ATT: begin
				dv_go = (den_q > plac_pkg::ATT_LIM);
				dv_n  = plac_pkg::ATT_NUM;
				dv_d  = den_q;
			end
			S_LDV: begin
				dv_go = 1'b1;
				dv_n  = DVN_W'(dmag) << 22;
				dv_d  = DEN_W'(len16_q);
			end
			S_RDV: begin
				dv_go = 1'b1;
				dv_n  = DVN_W'(rmag) << 14;
				dv_d  = DEN_W'(rlen_q);
			end
			default: begin dv_go = 1'b0; dv_n = '0; dv_d = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 1'b0;
			idx_q       <= '0;
			ambient_q   <= plac_pkg::AMBIENT_RST;
			quad_q      <= plac_pkg::QUADRATIC_RST;
			lin_q       <= plac_pkg::LINEAR_RST;
			const_q     <= plac_pkg::CONSTANT_RST;
			exp_q       <= plac_pkg::EXPONENT_RST;
			hp_q <= '0; nrm_q <= '0; vw_q <= '0; col_q <= '0; lp_q <= '0;
			refl_q <= '0; shadow_q <= 1'b0; lvalid_q <= 1'b0; last_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				sum_q[k] <= '0;
				l_q[k]   <= '0;
				r_q[k]   <= '0;
			end
			d2acc_q <= '0; d2_q <= '0; len16_q <= '0; rlen_q <= '0;
			den_q <= '0; att_q <= '0; dacc_q <= '0; nl_q <= '0;
			r2acc_q <= '0; t_q <= '0; acc_q <= '0; p_q <= '0; e_q <= '0;
			red_q <= '0; green_q <= '0; blue_q <= '0;
			out_valid_q <= 1'b0;
			dv_rem_q <= '0; dv_dsh_q <= '0; dv_quo_q <= '0;
			dv_ovf_q <= 1'b0; dv_busy_q <= 1'b0; dv_cnt_q <= '0;
			sq_x_q <= '0; sq_bit_q <= '0; sq_r_q <= '0; sq_busy_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					plac_pkg::REG_AMBIENT:   ambient_q <= cfg_data[plac_pkg::AMB_W-1:0];
					plac_pkg::REG_QUADRATIC: quad_q    <= cfg_data;
					plac_pkg::REG_LINEAR:    lin_q     <= cfg_data;
					plac_pkg::REG_CONSTANT:  const_q   <= cfg_data;
					plac_pkg::REG_EXPONENT:  exp_q     <= cfg_data[plac_pkg::EXP_W-1:0];
					default: ;
				endcase
			end

			if (state_q == S_EMIT && last_q && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			// divider: one quotient bit a cycle
			if (dv_go) begin
				dv_rem_q  <= dv_n;
				dv_dsh_q  <= DVS_W'(dv_d) << (DVQ_W - 1);
				dv_ovf_q  <= ({(DEN_W+DVQ_W-DVN_W)'(0), dv_n} >= {dv_d, DVQ_W'(0)});
				dv_quo_q  <= '0;
				dv_cnt_q  <= DVC_W'(DVQ_W);
				dv_busy_q <= 1'b1;
			end else if (dv_busy_q) begin
				if (DVS_W'(dv_rem_q) >= dv_dsh_q) begin
					dv_rem_q <= DVN_W'(DVS_W'(dv_rem_q) - dv_dsh_q);
					dv_quo_q <= {dv_quo_q[DVQ_W-2:0], 1'b1};
				end else begin
					dv_quo_q <= {dv_quo_q[DVQ_W-2:0], 1'b0};
				end
				dv_dsh_q  <= dv_dsh_q >> 1;
				dv_cnt_q  <= dv_cnt_q - DVC_W'(1);
				dv_busy_q <= (dv_cnt_q != DVC_W'(1));
			end

			// root unit: one result bit a cycle
			if (sq_busy_q) begin
				if ((SQ_W+1)'(sq_x_q) >= sq_try) begin
					sq_x_q <= SQ_W'((SQ_W+1)'(sq_x_q) - sq_try);
					sq_r_q <= (sq_r_q >> 1) + (SQ_W+1)'(sq_bit_q);
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q  <= sq_bit_q >> 2;
				sq_busy_q <= ((sq_bit_q >> 2) != '0);
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						hp_q     <= FW'(hit_point[FWK-1:0]);
						nrm_q    <= FW'(surface_normal[FWK-1:0]);
						vw_q     <= FW'(view_dir[FWK-1:0]);
						col_q    <= FW'(object_color[FWK-1:0]);
						lp_q     <= FW'(light_pos[FWK-1:0]);
						refl_q   <= reflectivity;
						shadow_q <= in_shadow;
						lvalid_q <= light_valid;
						last_q   <= last_light;
						idx_q    <= '0;
						ph_q     <= 1'b0;
						state_q  <= first_light ? S_AMB : S_CHK;
					end
				end
				S_AMB: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						sum_q[idx_q] <= plac_pkg::sat_add('0, prod_q[51:12]);
						idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
						if (idx_q == 2'd2)
							state_q <= S_CHK;
					end
				end
				S_CHK: begin
					d2acc_q <= '0;
					idx_q   <= '0;
					state_q <= (lvalid_q && !shadow_q) ? S_D2 : S_EMIT;
				end
				S_D2: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						d2acc_q <= d2_sum;
						idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
						if (idx_q == 2'd2) begin
							d2_q      <= d2_sat;
							sq_x_q    <= {d2_sat, 16'b0};
							sq_r_q    <= '0;
							sq_bit_q  <= SQ_W'(1) << (SQ_W - 2);
							sq_busy_q <= 1'b1;
							state_q   <= S_SQ1;
						end
					end
				end
				S_SQ1: begin
					if (!sq_busy_q) begin
						len16_q <= sq_r_q[ROOT_W-1:0];
						state_q <= S_DQL;
					end
				end
				S_DQL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						den_q   <= DEN_W'(prod_q[47:0]);
						state_q <= S_DQH;
					end
				end
				S_DQH: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						den_q   <= den_q + (DEN_W'(prod_q[23:0]) << 32);
						state_q <= S_DLN;
					end
				end
				S_DLN: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						den_q   <= den_q + (DEN_W'(prod_q[35:0]) << 8)
							+ (DEN_W'(const_q) << 16);
						state_q <= S_ATT;
					end
				end
				S_ATT: begin
					if (dv_go) begin
						state_q <= S_ATW;
					end else begin
						att_q   <= plac_pkg::ATT_ONE;
						state_q <= S_LEN;
					end
				end
				S_ATW: begin
					if (!dv_busy_q) begin
						att_q   <= plac_pkg::ATT_W'(dv_quo_q);
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					idx_q   <= '0;
					state_q <= (len16_q == '0) ? S_EMIT : S_LDV;
				end
				S_LDV: state_q <= S_LWT;
				S_LWT: begin
					if (!dv_busy_q) begin
						l_q[idx_q] <= d_w[idx_q][DW-1] ? -UNIT_W'(dv_unit) : UNIT_W'(dv_unit);
						idx_q      <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
						dacc_q     <= '0;
						state_q    <= (idx_q == 2'd2) ? S_NL : S_LDV;
					end
				end
				S_NL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						dacc_q <= dot_sum;
						idx_q  <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
						if (idx_q == 2'd2) begin
							nl_q    <= NL_W'(dot_t);
							state_q <= (dot_t > 0) ? S_DF1 : S_EMIT;
						end
					end
				end
				S_DF1: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						t_q     <= prod_q[41:14];
						state_q <= S_DF2;
					end
				end
				S_DF2: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						t_q     <= prod_q[43:16];
						state_q <= S_DF3;
					end
				end
				S_DF3: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						sum_q[idx_q] <= plac_pkg::sat_add(sum_q[idx_q], prod_q[51:12]);
						state_q      <= S_RN;
					end
				end
				S_RN: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						r_q[idx_q] <= R_W'(ACC_W'(l_q[idx_q])
							- plac_pkg::tdiv14(ACC_W'(prod_q) <<< 1));
						idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
						r2acc_q <= '0;
						state_q <= (idx_q == 2'd2) ? S_RR : S_DF1;
					end
				end
				S_RR: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						r2acc_q <= r2_sum;
						idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
						if (idx_q == 2'd2) begin
							sq_x_q    <= SQ_W'(r2_sum);
							sq_r_q    <= '0;
							sq_bit_q  <= SQ_W'(1) << (SQ_W - 2);
							sq_busy_q <= 1'b1;
							state_q   <= S_SQ2;
						end
					end
				end
				S_SQ2: begin
					if (!sq_busy_q) begin
						rlen_q  <= sq_r_q[ROOT_W-1:0];
						idx_q   <= '0;
						state_q <= (sq_r_q == '0) ? S_EMIT : S_RDV;
					end
				end
				S_RDV: state_q <= S_RWT;
				S_RWT: begin
					if (!dv_busy_q) begin
						r_q[idx_q] <= r_q[idx_q][R_W-1] ? -R_W'(dv_unit) : R_W'(dv_unit);
						idx_q      <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
						dacc_q     <= '0;
						state_q    <= (idx_q == 2'd2) ? S_PV : S_RDV;
					end
				end
				S_PV: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						dacc_q <= dot_sum;
						idx_q  <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
						if (idx_q == 2'd2) begin
							p_q     <= (dot_t > ACC_W'(16384)) ? plac_pkg::UNIT_ONE
								: UQ_W'(dot_t);
							acc_q   <= plac_pkg::UNIT_ONE;
							e_q     <= '0;
							state_q <= (dot_t > 0) ? S_POW : S_EMIT;
						end
					end
				end
				S_POW: begin
					if (!ph_q) begin
						if (e_q == exp_q)
							state_q <= S_SPC;
						else
							ph_q <= 1'b1;
					end else begin
						acc_q <= prod_q[28:14];
						e_q   <= e_q + 8'd1;
						ph_q  <= 1'b0;
					end
				end
				S_SPC: begin
					for (int k = 0; k < 3; k++)
						sum_q[k] <= plac_pkg::sat_add(sum_q[k], ADD_W'(acc_q[UQ_W-1:2]));
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (!out_valid_q || out_ready) begin
						red_q   <= (sum_q[0] > SUM_W'(plac_pkg::OUT_MAX)) ? plac_pkg::OUT_MAX
							: sum_q[0][plac_pkg::OUT_W-1:0];
						green_q <= (sum_q[1] > SUM_W'(plac_pkg::OUT_MAX)) ? plac_pkg::OUT_MAX
							: sum_q[1][plac_pkg::OUT_W-1:0];
						blue_q  <= (sum_q[2] > SUM_W'(plac_pkg::OUT_MAX)) ? plac_pkg::OUT_MAX
							: sum_q[2][plac_pkg::OUT_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!dv_busy_q && !sq_busy_q))
		else $error("arith unit busy in idle");

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat taken while working");

	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q |-> (state_q == S_AMB || state_q == S_D2 || state_q == S_DQL ||
			state_q == S_DQH || state_q == S_DLN || state_q == S_NL ||
			state_q == S_DF1 || state_q == S_DF2 || state_q == S_DF3 ||
			state_q == S_RN || state_q == S_RR || state_q == S_PV || state_q == S_POW))
		else $error("multiply phase outside multiply step");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit");

endmodule
`default_nettype wire
